// File: hdl/ade_pkg.sv
// ----------------------------------------------------------------------------
// ade_pkg: shared types and constants for the array deque engine
// Request and response transaction formats, operation and status codes,
// and the per-request bookkeeping handed from the controller to the top.
// ----------------------------------------------------------------------------
package ade_pkg;

  // default geometry
  localparam int DEPTH_DEF      = 8;
  localparam int DATA_WIDTH_DEF = 32;

  // width of the value fields on the ports
  localparam int VALUE_W = 32;

  // operation codes; codes 5 to 7 are no-ops
  typedef enum logic [2:0] {
    REQ_PUSH_REAR  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_REAR   = 3'd3,
    REQ_PEEK       = 3'd4
  } req_code_t;

  // response status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // request transaction
  typedef struct packed {
    req_code_t                  req_type;
    logic signed [VALUE_W-1:0]  item_value;
  } req_t;

  // response transaction
  typedef struct packed {
    logic signed [VALUE_W-1:0]  read_value;
    status_t                    status;
    logic                       now_empty;
    logic                       now_full;
  } rsp_t;

  // result bookkeeping for a request waiting on the RAM read
  typedef struct packed {
    status_t status;
    logic    now_empty;
    logic    now_full;
    logic    rd_used;
  } res_info_t;

endpackage

// File: hdl/ade_ram.sv
// ----------------------------------------------------------------------------
// ade_ram: generic single-port RAM
// One read or write per cycle; read data is registered and holds its value
// until the next read.
// ----------------------------------------------------------------------------
module ade_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // storage and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: hdl/ade_ctrl.sv
// ----------------------------------------------------------------------------
// ade_ctrl: deque index controller
// Holds head, tail and empty state, decodes each accepted request into at most one
// RAM access and produces the status and flags of its response.
// ----------------------------------------------------------------------------
module ade_ctrl #(
  parameter int DEPTH      = ade_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ade_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     acc,
  input  ade_pkg::req_t            req,
  output logic                     ram_rd_en,
  output logic                     ram_wr_en,
  output logic [$clog2(DEPTH)-1:0] ram_addr,
  output logic [DATA_WIDTH-1:0]    ram_wdata,
  output ade_pkg::res_info_t       info
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(DEPTH - 1);
  localparam logic [IDX_W-1:0] ZERO = '0;
  localparam logic [IDX_W-1:0] ONE  = IDX_W'(1);

  logic [IDX_W-1:0] head, head_next;
  logic [IDX_W-1:0] tail, tail_next;
  logic             empty, empty_next;

  // store item in the low DATA_WIDTH bits, zero above bit 31
  generate
    if (DATA_WIDTH <= ade_pkg::VALUE_W) begin : g_wr_narrow
      assign ram_wdata = req.item_value[DATA_WIDTH-1:0];
    end else begin : g_wr_wide
      assign ram_wdata = {{(DATA_WIDTH - ade_pkg::VALUE_W){1'b0}}, req.item_value};
    end
  endgenerate

  // request decode
  always_comb begin
    head_next   = head;
    tail_next   = tail;
    empty_next  = empty;
    ram_rd_en   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_addr    = head;
    info.status = ade_pkg::ST_OK;
    info.rd_used = 1'b0;
    case (req.req_type)
      ade_pkg::REQ_PUSH_REAR: begin
        if (empty) begin
          head_next  = ZERO;
          tail_next  = ZERO;
          empty_next = 1'b0;
          ram_wr_en  = acc;
          ram_addr   = ZERO;
        end else if (tail == LAST) begin
          info.status = ade_pkg::ST_NO_ROOM;
        end else begin
          tail_next = tail + ONE;
          ram_wr_en = acc;
          ram_addr  = tail + ONE;
        end
      end
      ade_pkg::REQ_PUSH_FRONT: begin
        if (empty || head == ZERO) begin
          info.status = ade_pkg::ST_NO_ROOM;
        end else begin
          head_next = head - ONE;
          ram_wr_en = acc;
          ram_addr  = head - ONE;
        end
      end
      ade_pkg::REQ_POP_FRONT: begin
        if (empty) begin
          info.status = ade_pkg::ST_EMPTY;
        end else begin
          ram_rd_en    = acc;
          ram_addr     = head;
          info.rd_used = 1'b1;
          if (head == tail) begin
            head_next  = ZERO;
            tail_next  = ZERO;
            empty_next = 1'b1;
          end else begin
            head_next = head + ONE;
          end
        end
      end
      ade_pkg::REQ_POP_REAR: begin
        if (empty) begin
          info.status = ade_pkg::ST_EMPTY;
        end else begin
          ram_rd_en    = acc;
          ram_addr     = tail;
          info.rd_used = 1'b1;
          if (head == tail) begin
            head_next  = ZERO;
            tail_next  = ZERO;
            empty_next = 1'b1;
          end else begin
            tail_next = tail - ONE;
          end
        end
      end
      ade_pkg::REQ_PEEK: begin
        if (empty) begin
          info.status = ade_pkg::ST_EMPTY;
        end else begin
          ram_rd_en    = acc;
          ram_addr     = head;
          info.rd_used = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // flags as they stand after the request
    info.now_empty = empty_next;
    info.now_full  = !empty_next && (tail_next == LAST);
  end

  // index state
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= ZERO;
      tail  <= ZERO;
      empty <= 1'b1;
    end else if (acc) begin
      head  <= head_next;
      tail  <= tail_next;
      empty <= empty_next;
    end
  end

endmodule

// File: hdl/array_deque_engine.sv
// ----------------------------------------------------------------------------
// array_deque_engine: double-ended queue in a fixed, non-wrapping array
// Slots live in a single-port RAM; head, tail and empty live in registers.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry request transactions: an operation code
//   (push rear, push front, pop front, pop rear, peek front) and a value.
//   out_valid/out_ready/out_data carry one response transaction per request:
//   the value read, a status code and the empty/full flags after the request.
//   Response path: a request's RAM read and its bookkeeping are registered
//   at acceptance, then its response is loaded into the output register.
//   Throughput: one request per cycle while the output is not stalled; each
//   request makes at most one access to the one RAM port, and indices update in
//   the cycle of acceptance, so a read always sees every earlier write.
//   Reset (rst, synchronous) empties the deque and drops any pending or
//   buffered response. Slot contents are not cleared.
//   When the receiver stalls, the output register and the pending stage
//   hold their transactions; in_ready drops once both are occupied and
//   rises again as soon as out_ready takes the output.
// ----------------------------------------------------------------------------
module array_deque_engine #(
  parameter int DEPTH      = ade_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ade_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  ade_pkg::req_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ade_pkg::rsp_t  out_data
);

  localparam int IDX_W = $clog2(DEPTH);

  logic                    in_acc;
  logic                    out_free;
  logic                    ram_rd_en;
  logic                    ram_wr_en;
  logic [IDX_W-1:0]        ram_addr;
  logic [DATA_WIDTH-1:0]   ram_wdata;
  logic [DATA_WIDTH-1:0]   ram_rdata;
  ade_pkg::res_info_t      acc_info;
  logic                    pend_valid;
  ade_pkg::res_info_t      pend_info;
  logic [ade_pkg::VALUE_W-1:0] rd_ext;

  // handshake
  assign out_free = !out_valid || out_ready;
  assign in_ready = !pend_valid || out_free;
  assign in_acc   = in_valid && in_ready;

  ade_ctrl #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .acc       (in_acc),
    .req       (in_data),
    .ram_rd_en (ram_rd_en),
    .ram_wr_en (ram_wr_en),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .info      (acc_info)
  );

  ade_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .rd_en (ram_rd_en),
    .wr_en (ram_wr_en),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // fit stored data to the 32-bit field: sign-extend or truncate
  generate
    if (DATA_WIDTH < ade_pkg::VALUE_W) begin : g_rd_narrow
      assign rd_ext = {{(ade_pkg::VALUE_W - DATA_WIDTH){ram_rdata[DATA_WIDTH-1]}},
                       ram_rdata};
    end else begin : g_rd_wide
      assign rd_ext = ram_rdata[ade_pkg::VALUE_W-1:0];
    end
  endgenerate

  // pending stage: waits for the RAM read data
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_acc) begin
      pend_valid <= 1'b1;
    end else if (out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pend_info <= acc_info;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pend_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && pend_valid) begin
      out_data.read_value <= pend_info.rd_used ? rd_ext : '0;
      out_data.status     <= pend_info.status;
      out_data.now_empty  <= pend_info.now_empty;
      out_data.now_full   <= pend_info.now_full;
    end
  end

  // a full deque is never empty
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.now_full && out_data.now_empty))
    else $error("response flags full and empty together");

  // only successful pops and peeks read the RAM
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    pend_valid && pend_info.rd_used |-> pend_info.status == ade_pkg::ST_OK)
    else $error("RAM read on a failed request");

  // a blocked pending response keeps its bookkeeping
  a_pend_hold: assert property (@(posedge clk) disable iff (rst)
    pend_valid && !out_free |=> pend_valid && $stable(pend_info))
    else $error("pending response lost while output stalled");

endmodule

// File: tb/array_deque_engine_tb.sv
// ----------------------------------------------------------------------------
// array_deque_engine_tb: self-checking bench for the array deque engine
// Drives request transactions through a directed table and then a random
// fill/drain mix. Random idle cycles are inserted on both channels. Each
// response is compared field by field with a behavioral deque model or a fixed table row.
// ----------------------------------------------------------------------------
module array_deque_engine_tb;

  localparam int SLOTS        = ade_pkg::DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1900;
  localparam int STALL_LIMIT  = 500;
  localparam int DRAIN_CYCLES = 20;

  // request codes outside the defined operations; they must be no-ops
  localparam logic [2:0] REQ_NOP_LO  = 3'd5;
  localparam logic [2:0] REQ_NOP_MID = 3'd6;
  localparam logic [2:0] REQ_NOP_HI  = 3'd7;

  // one row of the directed table; want_rsp is used only when fixed is set
  typedef struct {
    ade_pkg::req_t req;
    bit            fixed;
    ade_pkg::rsp_t want_rsp;
  } dir_row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  ade_pkg::req_t in_data;
  logic          out_valid;
  logic          out_ready;
  ade_pkg::rsp_t out_data;

  // typed expectation riding along with the current request transaction
  logic          typed_valid;
  ade_pkg::rsp_t typed_rsp;

  // deque model state
  logic [ade_pkg::VALUE_W-1:0] slot_mem [SLOTS];
  int unsigned                 head_idx;
  int unsigned                 tail_idx;
  bit                          is_empty;

  ade_pkg::rsp_t expected_rsp_q [$];
  dir_row_t      dir_tab [$];
  int            mismatch_count;
  int            idle_cycles;
  bit            tx_steady;
  bit            rx_steady;

  array_deque_engine DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic void clear_deque();
    head_idx = 0;
    tail_idx = 0;
    is_empty = 1'b1;
  endfunction

  // model of one request: updates the deque state, returns the response
  function automatic ade_pkg::rsp_t predict_deque(ade_pkg::req_t r);
    ade_pkg::rsp_t o;
    o        = '0;
    o.status = ade_pkg::ST_OK;
    case (r.req_type)
      ade_pkg::REQ_PUSH_REAR: begin
        if (is_empty) begin
          clear_deque();
          is_empty    = 1'b0;
          slot_mem[0] = r.item_value;
        end else if (tail_idx == SLOTS - 1) begin
          o.status = ade_pkg::ST_NO_ROOM;
        end else begin
          tail_idx++;
          slot_mem[tail_idx] = r.item_value;
        end
      end
      ade_pkg::REQ_PUSH_FRONT: begin
        if (is_empty || head_idx == 0) begin
          o.status = ade_pkg::ST_NO_ROOM;
        end else begin
          head_idx--;
          slot_mem[head_idx] = r.item_value;
        end
      end
      ade_pkg::REQ_POP_FRONT: begin
        if (is_empty) begin
          o.status = ade_pkg::ST_EMPTY;
        end else begin
          o.read_value = slot_mem[head_idx];
          if (head_idx == tail_idx) clear_deque();
          else head_idx++;
        end
      end
      ade_pkg::REQ_POP_REAR: begin
        if (is_empty) begin
          o.status = ade_pkg::ST_EMPTY;
        end else begin
          o.read_value = slot_mem[tail_idx];
          if (head_idx == tail_idx) clear_deque();
          else tail_idx--;
        end
      end
      ade_pkg::REQ_PEEK: begin
        if (is_empty) o.status = ade_pkg::ST_EMPTY;
        else o.read_value = slot_mem[head_idx];
      end
      default: begin
      end
    endcase
    o.now_empty = is_empty;
    o.now_full  = !is_empty && (tail_idx == SLOTS - 1);
    return o;
  endfunction

  task automatic check_response(ade_pkg::rsp_t got, ade_pkg::rsp_t want);
    if (got.read_value !== want.read_value)
      report_mismatch($sformatf("read_value got %h want %h", got.read_value, want.read_value));
    if (got.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.now_empty !== want.now_empty)
      report_mismatch($sformatf("now_empty got %b want %b", got.now_empty, want.now_empty));
    if (got.now_full !== want.now_full)
      report_mismatch($sformatf("now_full got %b want %b", got.now_full, want.now_full));
  endtask

  function automatic void add_row(logic [2:0] op, logic [ade_pkg::VALUE_W-1:0] val,
                                  bit fixed, logic [ade_pkg::VALUE_W-1:0] rd,
                                  ade_pkg::status_t st, bit emp, bit full);
    dir_row_t row;
    row.req.req_type        = ade_pkg::req_code_t'(op);
    row.req.item_value      = val;
    row.fixed               = fixed;
    row.want_rsp.read_value = rd;
    row.want_rsp.status     = st;
    row.want_rsp.now_empty  = emp;
    row.want_rsp.now_full   = full;
    dir_tab.push_back(row);
  endfunction

  function automatic int draw_wait(bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // extremes show up often; the rest is uniform
  function automatic logic [ade_pkg::VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // fill phases favor pushes, drain phases favor pops
  function automatic ade_pkg::req_t random_req(bit filling);
    ade_pkg::req_t r;
    int            pick;
    pick         = $urandom_range(0, 99);
    r.item_value = random_value();
    if (pick < 4)
      r.req_type = ade_pkg::req_code_t'($urandom_range(REQ_NOP_LO, REQ_NOP_HI));
    else if (filling)
      r.req_type = pick < 50 ? ade_pkg::REQ_PUSH_REAR : pick < 64 ? ade_pkg::REQ_PUSH_FRONT :
                   pick < 74 ? ade_pkg::REQ_POP_FRONT : pick < 84 ? ade_pkg::REQ_POP_REAR :
                   ade_pkg::REQ_PEEK;
    else
      r.req_type = pick < 14 ? ade_pkg::REQ_PUSH_REAR : pick < 30 ? ade_pkg::REQ_PUSH_FRONT :
                   pick < 58 ? ade_pkg::REQ_POP_FRONT : pick < 84 ? ade_pkg::REQ_POP_REAR :
                   ade_pkg::REQ_PEEK;
    return r;
  endfunction

  // present one request transaction and hold it until accepted
  task automatic send_req(ade_pkg::req_t r, bit fixed, ade_pkg::rsp_t fixed_rsp);
    int gap;
    if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
    gap = draw_wait(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_data     <= r;
    typed_valid <= fixed;
    typed_rsp   <= fixed_rsp;
    do @(posedge clk); while (!in_ready);
  endtask

  // stimulus
  initial begin
    bit filling;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_data     <= '0;
    out_ready   <= 1'b0;
    typed_valid <= 1'b0;
    typed_rsp   <= '0;

    // empty deque: pops, peek, front push and an unused code
    add_row(ade_pkg::REQ_POP_FRONT,  32'h0,         1'b1, 32'h0, ade_pkg::ST_EMPTY, 1'b1, 1'b0);
    add_row(ade_pkg::REQ_POP_REAR,   32'h0,         1'b1, 32'h0, ade_pkg::ST_EMPTY, 1'b1, 1'b0);
    add_row(ade_pkg::REQ_PEEK,       32'h0,         1'b1, 32'h0, ade_pkg::ST_EMPTY, 1'b1, 1'b0);
    add_row(ade_pkg::REQ_PUSH_FRONT, 32'h1111_1111, 1'b1, 32'h0, ade_pkg::ST_NO_ROOM,
            1'b1, 1'b0);
    add_row(REQ_NOP_LO,              32'hFFFF_FFFF, 1'b1, 32'h0, ade_pkg::ST_OK, 1'b1, 1'b0);
    // single item; front push refused at slot 0, then empty again both ways
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_FRONT, 32'h2222_2222, 1'b1, 32'h0, ade_pkg::ST_NO_ROOM,
            1'b0, 1'b0);
    add_row(ade_pkg::REQ_PEEK,       32'h0, 1'b1, 32'h7FFF_FFFF, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_POP_FRONT,  32'h0, 1'b1, 32'h7FFF_FFFF, ade_pkg::ST_OK, 1'b1, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h8000_0000, 1'b1, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_POP_REAR,   32'h0, 1'b1, 32'h8000_0000, ade_pkg::ST_OK, 1'b1, 1'b0);
    // fill to the last slot, then overflow the rear
    add_row(ade_pkg::REQ_PUSH_REAR,  32'hFFFF_FFFF, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h0000_0000, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h0000_0001, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h5555_5555, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'hAAAA_AAAA, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h1234_5678, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'hDEAD_BEEF, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h0F0F_0F0F, 1'b1, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b1);
    add_row(ade_pkg::REQ_PUSH_REAR,  32'h3333_3333, 1'b1, 32'h0, ade_pkg::ST_NO_ROOM,
            1'b0, 1'b1);
    // open slot 0 from the front and refill it
    add_row(ade_pkg::REQ_POP_FRONT,  32'h0,         1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PUSH_FRONT, 32'hCAFE_F00D, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_POP_REAR,   32'h0,         1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(REQ_NOP_MID,             32'h4444_4444, 1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);
    add_row(ade_pkg::REQ_PEEK,       32'h0,         1'b0, 32'h0, ade_pkg::ST_OK, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) send_req(dir_tab[i].req, dir_tab[i].fixed, dir_tab[i].want_rsp);

    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 31) == 0) filling = !filling;
      send_req(random_req(filling), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // let every response come back, then watch for strays
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // response side: random back-pressure with steady stretches
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      stall = draw_wait(rx_steady);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // scoreboard: check responses, then log new requests
  always @(posedge clk) begin
    ade_pkg::rsp_t want;
    if (rst) begin
      clear_deque();
      expected_rsp_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch($sformatf("response with none pending: %h", out_data));
        end else begin
          want = expected_rsp_q.pop_front();
          check_response(out_data, want);
        end
      end
      if (in_valid && in_ready) begin
        want = predict_deque(in_data);
        if (typed_valid) want = typed_rsp;
        expected_rsp_q.push_back(want);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: array_deque_engine.f
hdl/ade_pkg.sv
hdl/ade_ram.sv
hdl/ade_ctrl.sv
hdl/array_deque_engine.sv
tb/array_deque_engine_tb.sv
